FILE: src/dcmf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the dark channel minimum filter.
package dcmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 7;
    localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int COORD_LIMIT = 1024;
    localparam int WIDTH_LIMIT = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SLOT_W  = $clog2(STORE_ROWS);
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int COORD_W = 10;
    localparam int DIM_W   = COORD_W + 1;
    localparam int PIX_W   = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_geom;

    typedef struct packed {
        logic               vld;
        logic               last;
        logic [COL_W-1:0]   addr;
        logic [PIX_W-1:0]   dmin;
    } t_chain;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [SLOT_W-1:0]  slot;
    } t_pos;

    function automatic t_pos adv_pos(input t_pos p, input t_geom g);
        t_pos             q;
        logic [DIM_W-1:0] col_inc;
        logic [DIM_W-1:0] row_inc;
        q       = p;
        col_inc = {1'b0, p.col} + DIM_W'(1);
        row_inc = {1'b0, p.row} + DIM_W'(1);
        if (col_inc >= g.width) begin
            q.col = '0;
            if (row_inc >= g.height) begin
                q.row  = '0;
                q.slot = '0;
            end else begin
                q.row  = row_inc[COORD_W-1:0];
                q.slot = (p.slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : p.slot + SLOT_W'(1);
            end
        end else begin
            q.col = col_inc[COORD_W-1:0];
        end
        return q;
    endfunction

endpackage

FILE: src/dcmf_if.sv
`timescale 1ns / 1ps
// Pixel and dark value stream interfaces with valid/ready handshake.
interface dcmf_pix_if import dcmf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;

    modport source (output valid, output req_type, output blue, output green, output red,
                    input ready);
    modport sink   (input valid, input req_type, input blue, input green, input red,
                    output ready);
endinterface

interface dcmf_dark_if import dcmf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   dark_value;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               frame_end;

    modport source (output valid, output dark_value, output out_col, output out_row,
                    output frame_end, input ready);
    modport sink   (input valid, input dark_value, input out_col, input out_row,
                    input frame_end, output ready);
endinterface

FILE: src/dark_channel_min_filter_core.sv
`timescale 1ns / 1ps
// Top level: input sequencing, window check, cell chain and output register.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-------------------------------------------
//  i_pix     | in  | valid/ready      | req_type, blue, green, red
//  o_dark    | out | valid/ready      | dark_value, out_col, out_row, frame_end
//  APB       | in  | psel/penable     | radius, width, height at 0x0, 0x4, 0x8
//
//  One transaction at a time. A pixel or flush that yields no result goes back to idle
//  after the window check. One that yields a result goes on to the column sweep, which
//  feeds the chain of row cells one column a cycle; it then waits until the last cell
//  delivers the column minimum, and then puts the result into the output register.
//  A full output register stalls the result until the register is read or free.
//  Reset clears positions and the output valid; the store needs no clearing pass.
module dark_channel_min_filter_core import dcmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dcmf_pix_if.sink              i_pix,
    dcmf_dark_if.source           o_dark,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_DRAIN, ST_PUT} t_state;

    t_geom geom;

    t_state             r_state, n_state;
    t_pos               r_in, n_in;
    t_pos               r_emit, n_emit;
    logic               r_out_vld, n_out_vld;

    logic [COORD_W-1:0] r_lim_row, n_lim_row;
    logic [COORD_W-1:0] r_lim_col, n_lim_col;
    logic               r_lim_incl, n_lim_incl;
    logic               r_lim_all, n_lim_all;
    logic [COORD_W-1:0] r_scan_col, n_scan_col;
    logic [COORD_W-1:0] r_last_col, n_last_col;
    logic [STORE_ROWS-1:0] r_mask, n_mask;
    logic [PIX_W-1:0]   r_acc, n_acc;
    logic [PIX_W-1:0]   r_dark_value, n_dark_value;
    logic [COORD_W-1:0] r_out_col, n_out_col;
    logic [COORD_W-1:0] r_out_row, n_out_row;
    logic               r_frame_end, n_frame_end;

    t_pos               in_res, em_res;
    logic               frame_done;
    logic               pix_wr;
    logic [PIX_W-1:0]   pix_min;
    logic [STORE_ROWS-1:0] w_wen;

    logic [DIM_W-1:0]   rad_ext, nr_sum, nc_sum, h_last, w_last;
    logic [COORD_W-1:0] nr, nc, r0, c0;
    logic [COORD_W-1:0] rad_c;
    logic [SLOT_W-1:0]  rad_s, r0slot, span, kk, ring_gap;
    logic [STORE_ROWS-1:0] mask;
    logic               emit_ok;
    logic               out_last;

    t_chain             w_chain [STORE_ROWS+1];
    t_chain             tail;

    dcmf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    // resolve stale positions at the start of a transaction
    always_comb begin
        in_res = r_in;
        if (({1'b0, r_in.row} >= geom.height) || ({1'b0, r_in.col} >= geom.width)) begin
            in_res = '0;
        end
        em_res = r_emit;
        if (({1'b0, r_emit.row} >= geom.height) || ({1'b0, r_emit.col} >= geom.width)) begin
            em_res = '0;
        end
        frame_done = (in_res.row == '0) && (in_res.col == '0) &&
                     ((em_res.row != '0) || (em_res.col != '0));
    end

    always_comb begin
        pix_min = (i_pix.blue < i_pix.green) ? i_pix.blue : i_pix.green;
        if (i_pix.red < pix_min) begin
            pix_min = i_pix.red;
        end
    end

    // window bounds of the next output
    always_comb begin
        rad_ext = DIM_W'(geom.rad);
        rad_c   = COORD_W'(geom.rad);
        rad_s   = SLOT_W'(geom.rad);
        h_last  = geom.height - DIM_W'(1);
        w_last  = geom.width - DIM_W'(1);
        nr_sum  = {1'b0, r_emit.row} + rad_ext;
        nc_sum  = {1'b0, r_emit.col} + rad_ext;
        nr      = (nr_sum > h_last) ? h_last[COORD_W-1:0] : nr_sum[COORD_W-1:0];
        nc      = (nc_sum > w_last) ? w_last[COORD_W-1:0] : nc_sum[COORD_W-1:0];
        r0      = (r_emit.row >= rad_c) ? r_emit.row - rad_c : '0;
        c0      = (r_emit.col >= rad_c) ? r_emit.col - rad_c : '0;
        span    = SLOT_W'(nr - r0);
        if (r_emit.row < rad_c) begin
            r0slot = '0;
        end else if (r_emit.slot >= rad_s) begin
            r0slot = r_emit.slot - rad_s;
        end else begin
            r0slot = SLOT_W'({1'b0, r_emit.slot} + (SLOT_W+1)'(STORE_ROWS) - {1'b0, rad_s});
        end
        for (int k = 0; k < STORE_ROWS; k++) begin
            kk = SLOT_W'(k);
            if (kk >= r0slot) begin
                ring_gap = kk - r0slot;
            end else begin
                ring_gap = SLOT_W'({1'b0, kk} + (SLOT_W+1)'(STORE_ROWS) - {1'b0, r0slot});
            end
            mask[k] = (ring_gap <= span);
        end
        emit_ok = r_lim_all || (nr < r_lim_row) ||
                  ((nr == r_lim_row) && (r_lim_incl ? (nc <= r_lim_col) : (nc < r_lim_col)));
        out_last = ({1'b0, r_emit.row} == h_last) && ({1'b0, r_emit.col} == w_last);
    end

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_emit       = r_emit;
        n_out_vld    = r_out_vld;
        n_lim_row    = r_lim_row;
        n_lim_col    = r_lim_col;
        n_lim_incl   = r_lim_incl;
        n_lim_all    = r_lim_all;
        n_scan_col   = r_scan_col;
        n_last_col   = r_last_col;
        n_mask       = r_mask;
        n_acc        = r_acc;
        n_dark_value = r_dark_value;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_frame_end  = r_frame_end;
        pix_wr       = 1'b0;

        if (r_out_vld && o_dark.ready) begin
            n_out_vld = 1'b0;
        end
        if (tail.vld && (tail.dmin < r_acc)) begin
            n_acc = tail.dmin;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_state   = ST_CHECK;
                    n_lim_row = in_res.row;
                    n_lim_col = in_res.col;
                    if (i_pix.req_type == REQ_PIXEL) begin
                        pix_wr     = 1'b1;
                        n_lim_incl = 1'b1;
                        n_lim_all  = 1'b0;
                        n_in       = adv_pos(in_res, geom);
                        n_emit     = frame_done ? '0 : em_res;
                    end else begin
                        n_lim_incl = 1'b0;
                        n_lim_all  = frame_done;
                        n_in       = in_res;
                        n_emit     = em_res;
                    end
                end
            end
            ST_CHECK: begin
                if (emit_ok) begin
                    n_state    = ST_SCAN;
                    n_scan_col = c0;
                    n_last_col = nc;
                    n_mask     = mask;
                    n_acc      = '1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                n_scan_col = r_scan_col + COORD_W'(1);
                if (r_scan_col == r_last_col) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (tail.vld && tail.last) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!r_out_vld || o_dark.ready) begin
                    n_out_vld    = 1'b1;
                    n_dark_value = r_acc;
                    n_out_col    = r_emit.col;
                    n_out_row    = r_emit.row;
                    n_frame_end  = out_last;
                    n_emit       = adv_pos(r_emit, geom);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in      <= '0;
            r_emit    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in      <= n_in;
            r_emit    <= n_emit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim_row    <= n_lim_row;
        r_lim_col    <= n_lim_col;
        r_lim_incl   <= n_lim_incl;
        r_lim_all    <= n_lim_all;
        r_scan_col   <= n_scan_col;
        r_last_col   <= n_last_col;
        r_mask       <= n_mask;
        r_acc        <= n_acc;
        r_dark_value <= n_dark_value;
        r_out_col    <= n_out_col;
        r_out_row    <= n_out_row;
        r_frame_end  <= n_frame_end;
    end

    assign w_chain[0].vld  = (r_state == ST_SCAN);
    assign w_chain[0].last = (r_scan_col == r_last_col);
    assign w_chain[0].addr = COL_W'(r_scan_col);
    assign w_chain[0].dmin = '1;

    for (genvar k = 0; k < STORE_ROWS; k++) begin : g_cell
        assign w_wen[k] = pix_wr && (in_res.slot == SLOT_W'(k));

        dcmf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wen   (w_wen[k]),
            .i_waddr (COL_W'(in_res.col)),
            .i_wdata (pix_min),
            .i_en    (r_mask[k]),
            .i_chain (w_chain[k]),
            .o_chain (w_chain[k+1])
        );
    end

    assign tail = w_chain[STORE_ROWS];

    assign i_pix.ready       = (r_state == ST_IDLE);
    assign o_dark.valid      = r_out_vld;
    assign o_dark.dark_value = r_dark_value;
    assign o_dark.out_col    = r_out_col;
    assign o_dark.out_row    = r_out_row;
    assign o_dark.frame_end  = r_frame_end;

endmodule

FILE: src/dcmf_cell.sv
`timescale 1ns / 1ps
// One row bank of the minimum store with its stage of the column minimum chain.
module dcmf_cell import dcmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wen,
    input  logic [COL_W-1:0] i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_en,
    input  t_chain           i_chain,
    output t_chain           o_chain
);

    logic [PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd;
    logic [PIX_W-1:0] r_min;
    logic [COL_W-1:0] r_addr;
    logic             r_vld;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_chain.addr];
    end

    always_ff @(posedge i_clk) begin
        r_min  <= i_chain.dmin;
        r_addr <= i_chain.addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_vld  <= i_chain.vld;
            r_last <= i_chain.last;
        end
    end

    assign o_chain.vld  = r_vld;
    assign o_chain.last = r_last;
    assign o_chain.addr = r_addr;
    assign o_chain.dmin = (i_en && (r_rd < r_min)) ? r_rd : r_min;

endmodule

FILE: src/dcmf_cfg.sv
`timescale 1ns / 1ps
// APB register file for radius and frame size, with clamped geometry out.
module dcmf_cfg import dcmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_geom                 o_geom
);

    logic [2:0]       r_radius;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 3'd7;
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(360);
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_RADIUS: r_radius <= pwdata[2:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = APB_DATA_W'(r_radius);
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        o_geom.rad = (r_radius > 3'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_radius);

        if (r_width == '0) begin
            o_geom.width = DIM_W'(1);
        end else if (r_width > DIM_W'(WIDTH_LIMIT)) begin
            o_geom.width = DIM_W'(WIDTH_LIMIT);
        end else begin
            o_geom.width = r_width;
        end

        if (r_height == '0) begin
            o_geom.height = DIM_W'(1);
        end else if (r_height > DIM_W'(COORD_LIMIT)) begin
            o_geom.height = DIM_W'(COORD_LIMIT);
        end else begin
            o_geom.height = r_height;
        end
    end

endmodule

FILE: src/dcmf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the dark channel filter core, bound to the top level.
module dcmf_checker import dcmf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [PIX_W-1:0]   i_out_dark,
    input logic [COORD_W-1:0] i_out_col,
    input logic [COORD_W-1:0] i_out_row,
    input logic               i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_dark) && $stable(i_out_col) && $stable(i_out_row))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a transaction is in flight");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a transaction in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("register port not ready");

endmodule

bind dark_channel_min_filter_core dcmf_checker u_dcmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_dark.valid),
    .i_out_ready (o_dark.ready),
    .i_out_dark  (o_dark.dark_value),
    .i_out_col   (o_dark.out_col),
    .i_out_row   (o_dark.out_row),
    .i_pready    (pready)
);
